/* sv/ccwt_pkg.sv */
// Shared types, constants and the default class map of the word tokenizer.
package ccwt_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int DEPTH_BITS  = 8;
	localparam int TABLE_DEPTH = 256;

	localparam logic [OFFSET_BITS-1:0] POS_MAX   = '1;
	localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = '1;
	localparam logic [15:0]            CNT_MAX   = 16'hFFFF;

	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_DEL   = 8'h7F;
	localparam logic [7:0] CHR_EQ    = 8'h3D;
	localparam logic [7:0] CHR_BAR   = 8'h7C;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_CLASS = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CLS_WORD  = 3'd0,
		CLS_SEP   = 3'd1,
		CLS_NL    = 3'd2,
		CLS_QUOTE = 3'd3,
		CLS_OPEN  = 3'd4,
		CLS_CLOSE = 3'd5
	} class_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic [2:0] class_code;
	} in_t;

	typedef struct packed {
		logic [15:0] word_start;
		logic [15:0] word_length;
		logic [15:0] line_number;
		logic [15:0] word_in_line;
		logic        ends_line;
		logic        overflow;
	} out_t;

	// Item held in the lookup stage while its class is read.
	typedef struct packed {
		logic       vld;
		logic [1:0] kind;
		logic [7:0] byte_value;
	} stage_t;

	// Word produced by the parse unit in the current cycle.
	typedef struct packed {
		logic vld;
		out_t word;
	} emit_t;

	function automatic class_t default_class(input logic [7:0] b);
		class_t c;
		c = CLS_WORD;
		if (b == CHR_LF || b == CHR_CR) begin
			c = CLS_NL;
		end else if (b <= CHR_SPACE || b >= CHR_DEL || b == CHR_EQ || b == CHR_BAR) begin
			c = CLS_SEP;
		end
		return c;
	endfunction

endpackage

/* sv/ccwt_class_mem.sv */
// Class table: 256-entry synchronous memory with per-entry written bits.
module ccwt_class_mem (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [7:0]           wr_addr,
	input  logic [2:0]           wr_cls,
	input  logic                 rd_en,
	input  logic [7:0]           rd_addr,
	output ccwt_pkg::class_t     rd_cls
);
	import ccwt_pkg::*;

	logic [2:0]             mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] written_q;
	logic [2:0]             rd_data_q;
	logic                   rd_written_q;
	logic [7:0]             rd_addr_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_cls;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	// Unwritten entries read as their reset class.
	assign rd_cls = rd_written_q ? class_t'(rd_data_q) : default_class(rd_addr_q);

endmodule

/* sv/ccwt_parse.sv */
// Parse state and word emission, one item per cycle while advance is high.
module ccwt_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  ccwt_pkg::stage_t  item,
	input  ccwt_pkg::class_t  cls,
	input  logic              advance,
	output ccwt_pkg::emit_t   emit
);
	import ccwt_pkg::*;

	logic [OFFSET_BITS-1:0] pos_q, tb_q, pos_n, tb_n, nxt, len;
	logic [7:0]             quote_q, quote_n;
	logic [DEPTH_BITS-1:0]  depth_q, depth_n;
	logic [15:0]            line_q, line_n, wol_q, wol_n;
	logic                   sat_q, sat_n;
	logic                   hit, eol, at_max, at_begin;
	logic [31:0]            start_w, len_w;

	always_comb begin
		pos_n    = pos_q;
		tb_n     = tb_q;
		quote_n  = quote_q;
		depth_n  = depth_q;
		line_n   = line_q;
		wol_n    = wol_q;
		sat_n    = sat_q;
		hit      = 1'b0;
		eol      = 1'b0;
		at_max   = (pos_q == POS_MAX);
		at_begin = (pos_q == tb_q);
		nxt      = at_max ? POS_MAX : pos_q + 1'b1;
		len      = pos_q - tb_q;
		if (item.vld) begin
			unique case (item.kind)
				KIND_END: begin
					hit     = (pos_q > tb_q);
					pos_n   = '0;
					tb_n    = '0;
					quote_n = '0;
					depth_n = '0;
					line_n  = '0;
					wol_n   = '0;
					sat_n   = 1'b0;
				end
				KIND_DATA: begin
					sat_n = sat_q | at_max;
					pos_n = nxt;
					unique case (cls)
						CLS_SEP: begin
							if (quote_q == '0 && depth_q == '0) begin
								hit  = !at_begin;
								tb_n = nxt;
							end
						end
						CLS_NL: begin
							hit  = 1'b1;
							eol  = 1'b1;
							tb_n = nxt;
							if (line_q != CNT_MAX) begin
								line_n = line_q + 16'd1;
							end
						end
						CLS_QUOTE: begin
							if (quote_q == '0 && at_begin) begin
								quote_n = item.byte_value;
								tb_n    = nxt;
							end else if (quote_q != '0 && quote_q == item.byte_value) begin
								quote_n = '0;
								hit     = 1'b1;
								tb_n    = nxt;
							end
						end
						CLS_OPEN: begin
							if (at_begin || depth_q != '0) begin
								if (depth_q != DEPTH_MAX) begin
									depth_n = depth_q + 1'b1;
								end
							end
							if (at_begin) begin
								tb_n = nxt;
							end
						end
						CLS_CLOSE: begin
							if (depth_q != '0) begin
								depth_n = depth_q - 1'b1;
								if (depth_q == DEPTH_BITS'(1)) begin
									hit  = 1'b1;
									tb_n = nxt;
								end
							end
						end
						CLS_WORD: begin
						end
					endcase
					// Count the word on its line; a newline restarts the count.
					if (cls == CLS_NL) begin
						wol_n = '0;
					end else if (hit && wol_q != CNT_MAX) begin
						wol_n = wol_q + 16'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign start_w = 32'(tb_q);
	assign len_w   = 32'(len);

	always_comb begin
		emit.vld               = hit;
		emit.word.word_start   = start_w[15:0];
		emit.word.word_length  = len_w[15:0];
		emit.word.line_number  = line_q;
		emit.word.word_in_line = wol_q;
		emit.word.ends_line    = eol;
		emit.word.overflow     = (item.kind == KIND_END) ? sat_q : sat_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tb_q    <= '0;
			quote_q <= '0;
			depth_q <= '0;
			line_q  <= '0;
			wol_q   <= '0;
			sat_q   <= 1'b0;
		end else if (advance) begin
			pos_q   <= pos_n;
			tb_q    <= tb_n;
			quote_q <= quote_n;
			depth_q <= depth_n;
			line_q  <= line_n;
			wol_q   <= wol_n;
			sat_q   <= sat_n;
		end
	end

endmodule

/* sv/char_class_word_tokenizer_core.sv */
// Top level of the character-class word tokenizer.
//
// Input channel (in_valid/in_ready/in_data) carries one beat per item: a data
// byte, a class table write, or an end-of-data mark. Output channel
// (out_valid/out_ready/out_data) carries one beat per emitted word: start
// offset, length, line number, index in line, newline flag and overflow flag.
//
// Throughput: one item per cycle while the output is not stalled. The class
// lookup is a read of the 256-entry table memory; the parse state update and
// word decision act on the registered lookup result, so the table port and the
// parse unit each see one item per cycle when unstalled. The beat that ends a
// word passes the lookup stage and the output register before out_valid rises.
// Class writes take effect for every data beat accepted after them.
//
// Reset clears the parse state, the output valid flag and all table written
// bits at once; unwritten table entries read as their default class, so the
// block takes items as soon as reset is released.
// When the receiver stalls, the output register holds its word; the lookup
// stage keeps running until it has a second word to hand over, then holds
// and in_ready drops until the output beat is taken.
module char_class_word_tokenizer_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ccwt_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ccwt_pkg::out_t  out_data
);
	import ccwt_pkg::*;

	stage_t  st_s1;
	class_t  cls_s1;
	emit_t   emit;
	logic    accept, stall, advance, wr_en;
	logic    out_valid_q;
	out_t    out_q;

	assign accept  = in_valid && in_ready;
	// Hold the lookup stage only when it has a word and the output is full and not taken.
	assign stall   = emit.vld && out_valid_q && !out_ready;
	assign in_ready = !stall;
	assign advance = st_s1.vld && !stall;

	// Drop class writes with codes past the last class.
	assign wr_en = accept && (in_data.kind == KIND_CLASS) && (in_data.class_code <= CLS_CLOSE);

	ccwt_class_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (in_data.byte_value),
		.wr_cls  (in_data.class_code),
		.rd_en   (accept),
		.rd_addr (in_data.byte_value),
		.rd_cls  (cls_s1)
	);

	// Lookup stage: data and end beats advance to the parse unit; class writes
	// finish at the table and other kinds vanish here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (accept) begin
			st_s1.vld        <= (in_data.kind == KIND_DATA) || (in_data.kind == KIND_END);
			st_s1.kind       <= in_data.kind;
			st_s1.byte_value <= in_data.byte_value;
		end else if (advance) begin
			st_s1.vld <= 1'b0;
		end
	end

	ccwt_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (st_s1),
		.cls     (cls_s1),
		.advance (advance),
		.emit    (emit)
	);

	// Output register: load a new word, or clear once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit.vld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit.vld) begin
			out_q <= emit.word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/ccwt_checker.sv */
// Port-level checks of the tokenizer, bound to the top level.
module ccwt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input ccwt_pkg::in_t   in_data,
	input logic            out_valid,
	input logic            out_ready,
	input ccwt_pkg::out_t  out_data
);
	import ccwt_pkg::*;

	// A held word stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// Input backpressure only comes from a stalled full output.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output stall");

	// A fresh word follows an accepted data or end beat, via the lookup stage and the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2)
			&& ($past(in_data.kind, 2) != KIND_CLASS))
		else $error("word appeared without a matching input beat");

	// A word never runs past the last offset.
	a_word_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (OFFSET_BITS != 16)
			|| ((17'(out_data.word_start) + 17'(out_data.word_length)) <= 17'h0FFFF))
		else $error("word extends beyond offset range");

endmodule

bind char_class_word_tokenizer_core ccwt_checker u_ccwt_checker (.*);

/* sim/char_class_word_tokenizer_core_tb.sv */
// Self-checking testbench for the character-class word tokenizer core.
module char_class_word_tokenizer_core_tb;
	import ccwt_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 5;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int MAX_REPORTS  = 30;

	// Item kind and class codes that the block must ignore.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [2:0] CODE_BAD_LO = 3'd6;
	localparam logic [2:0] CODE_BAD_HI = 3'd7;

	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_DQ   = 8'h22;
	localparam logic [7:0] CH_SQ   = 8'h27;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_LBRK = 8'h5B;
	localparam logic [7:0] CH_RBRK = 8'h5D;
	localparam logic [7:0] CH_A    = 8'h61;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	char_class_word_tokenizer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predicted parse state of the block.
	logic [OFFSET_BITS-1:0] pos;
	logic [OFFSET_BITS-1:0] tok_begin;
	logic [7:0]             quote_byte;
	logic [DEPTH_BITS-1:0]  depth;
	logic [15:0]            line_cnt;
	logic [15:0]            words_cnt;
	logic                   sat;
	class_t                 class_map [TABLE_DEPTH];

	out_t words_due [$];       // words predicted but not yet seen on the output
	in_t  items_to_send [$];   // items waiting for the input channel
	out_t due_w;

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_off = 1'b0;

	int n_items  = 0;
	int n_words  = 0;
	int n_eol    = 0;
	int n_ovf    = 0;
	int n_errors = 0;

	function automatic void clear_parse_state();
		pos        = '0;
		tok_begin  = '0;
		quote_byte = '0;
		depth      = '0;
		line_cnt   = '0;
		words_cnt  = '0;
		sat        = 1'b0;
	endfunction

	function automatic void queue_word(input logic [OFFSET_BITS-1:0] start,
			input logic [OFFSET_BITS-1:0] len, input logic eol);
		out_t w;
		w.word_start   = 16'(start);
		w.word_length  = 16'(len);
		w.line_number  = line_cnt;
		w.word_in_line = words_cnt;
		w.ends_line    = eol;
		w.overflow     = sat;
		words_due.push_back(w);
		if (words_cnt < CNT_MAX) begin
			words_cnt = words_cnt + 1'b1;
		end
	endfunction

	// Advance the predicted state by one accepted item; queue any word it ends.
	function automatic void tokenize_item(input in_t it);
		logic [OFFSET_BITS-1:0] s;
		logic [OFFSET_BITS-1:0] nxt;
		class_t                 c;
		case (it.kind)
			KIND_CLASS: begin
				if (it.class_code <= CLS_CLOSE) begin
					class_map[it.byte_value] = class_t'(it.class_code);
				end
			end
			KIND_END: begin
				if (pos > tok_begin) begin
					queue_word(tok_begin, pos - tok_begin, 1'b0);
				end
				clear_parse_state();
			end
			KIND_DATA: begin
				s = pos;
				if (s == POS_MAX) begin
					nxt = POS_MAX;
					sat = 1'b1;
				end else begin
					nxt = s + 1'b1;
				end
				c = class_map[it.byte_value];
				case (c)
					CLS_SEP: begin
						if (quote_byte == '0 && depth == '0) begin
							if (s != tok_begin) begin
								queue_word(tok_begin, s - tok_begin, 1'b0);
							end
							tok_begin = nxt;
						end
					end
					CLS_NL: begin
						// Newline ends the word even inside quotes or brackets.
						queue_word(tok_begin, s - tok_begin, 1'b1);
						tok_begin = nxt;
						if (line_cnt < CNT_MAX) begin
							line_cnt = line_cnt + 1'b1;
						end
						words_cnt = '0;
					end
					CLS_QUOTE: begin
						if (quote_byte == '0 && s == tok_begin) begin
							quote_byte = it.byte_value;
							tok_begin  = nxt;
						end else if (quote_byte != '0 && quote_byte == it.byte_value) begin
							quote_byte = '0;
							queue_word(tok_begin, s - tok_begin, 1'b0);
							tok_begin = nxt;
						end
					end
					CLS_OPEN: begin
						if (s == tok_begin) begin
							if (depth < DEPTH_MAX) begin
								depth = depth + 1'b1;
							end
							tok_begin = nxt;
						end else if (depth != '0 && depth < DEPTH_MAX) begin
							depth = depth + 1'b1;
						end
					end
					CLS_CLOSE: begin
						if (depth != '0) begin
							depth = depth - 1'b1;
							if (depth == '0) begin
								queue_word(tok_begin, s - tok_begin, 1'b0);
								tok_begin = nxt;
							end
						end
					end
					default: begin
					end
				endcase
				pos = nxt;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			n_errors++;
			if (n_errors <= MAX_REPORTS) begin
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		end
	endfunction

	// Stimulus builders: every item lands on the send queue.
	function automatic void add_item(input logic [1:0] k, input logic [7:0] b,
			input logic [2:0] c);
		in_t it;
		it.kind       = k;
		it.byte_value = b;
		it.class_code = c;
		items_to_send.push_back(it);
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		add_item(KIND_DATA, b, 3'($urandom_range(7)));
	endfunction

	function automatic void add_class(input logic [7:0] b, input logic [2:0] c);
		add_item(KIND_CLASS, b, c);
	endfunction

	function automatic void add_end();
		add_item(KIND_END, 8'($urandom_range(255)), 3'($urandom_range(7)));
	endfunction

	function automatic void add_letters(input int n);
		repeat (n) add_byte(8'(CH_A + $urandom_range(25)));
	endfunction

	// One token: mostly well-formed words, separators, newlines, quotes and brackets; some noise.
	function automatic void add_token();
		int         r;
		int         d;
		logic [7:0] q;
		r = $urandom_range(99);
		if (r < 45) begin
			add_letters($urandom_range(1, 6));
		end else if (r < 60) begin
			case ($urandom_range(5))
				0: add_byte(CHR_SPACE);
				1: add_byte(CH_TAB);
				2: add_byte(CHR_EQ);
				3: add_byte(CHR_BAR);
				4: add_byte(8'(8'h80 + $urandom_range(127)));
				default: add_byte(8'($urandom_range(9)));
			endcase
		end else if (r < 70) begin
			add_byte($urandom_range(1) ? CHR_LF : CHR_CR);
		end else if (r < 78) begin
			q = $urandom_range(1) ? CH_DQ : CH_SQ;
			add_byte(q);
			add_letters($urandom_range(0, 4));
			if ($urandom_range(3) == 0) add_byte(CHR_SPACE);
			if ($urandom_range(9) == 0) add_byte(CHR_LF);
			add_letters($urandom_range(0, 3));
			add_byte(q);
		end else if (r < 86) begin
			d = $urandom_range(1, 3);
			repeat (d) add_byte($urandom_range(1) ? CH_LPAR : CH_LBRK);
			add_letters($urandom_range(0, 3));
			if ($urandom_range(3) == 0) add_byte(CHR_SPACE);
			add_letters($urandom_range(0, 3));
			repeat (d) add_byte($urandom_range(1) ? CH_RPAR : CH_RBRK);
		end else if (r < 90) begin
			// broken sequence: a lone quote, open or close
			case ($urandom_range(2))
				0: add_byte($urandom_range(1) ? CH_DQ : CH_SQ);
				1: add_byte(CH_LPAR);
				default: add_byte(CH_RBRK);
			endcase
		end else if (r < 95) begin
			case ($urandom_range(2))
				0: add_class(8'(CH_A + $urandom_range(25)), 3'($urandom_range(7)));
				1: add_class(8'(CH_DQ + $urandom_range(7)), 3'($urandom_range(7)));
				default: add_class(8'($urandom_range(255)), 3'($urandom_range(7)));
			endcase
		end else if (r < 97) begin
			add_item(KIND_UNUSED, 8'($urandom_range(255)), 3'($urandom_range(7)));
		end else begin
			add_byte(8'($urandom_range(255)));
		end
	endfunction

	// A short file: restore the punctuation and newline classes, random tokens, end of data.
	function automatic void add_random_file(input int n);
		int target;
		add_class(CH_DQ, CLS_QUOTE);
		add_class(CH_SQ, CLS_QUOTE);
		add_class(CH_LPAR, CLS_OPEN);
		add_class(CH_LBRK, CLS_OPEN);
		add_class(CH_RPAR, CLS_CLOSE);
		add_class(CH_RBRK, CLS_CLOSE);
		add_class(CHR_LF, CLS_NL);
		add_class(CHR_CR, CLS_NL);
		target = items_to_send.size() + n;
		while (items_to_send.size() < target) add_token();
		add_end();
	endfunction

	// Run the queued items under one idling mix until every word is back.
	task automatic run_phase(input int snd, input int rcv);
		send_idle_pct  = snd;
		recv_stall_pct = rcv;
		do @(negedge clk);
		while (items_to_send.size() != 0 || in_valid || words_due.size() != 0);
	endtask

	// Driver: offer the next item when the slot is free, with random idling; predict on each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				tokenize_item(in_data);
				n_items++;
			end
			// Hold valid and payload until the beat is taken.
			if (!in_valid || in_ready) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data  <= items_to_send.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each output beat with the oldest predicted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (words_due.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS) begin
						$error("word with nothing expected: start %0d length %0d",
							out_data.word_start, out_data.word_length);
					end
				end else begin
					due_w = words_due.pop_front();
					check_field("word_start", due_w.word_start, out_data.word_start);
					check_field("word_length", due_w.word_length, out_data.word_length);
					check_field("line_number", due_w.line_number, out_data.line_number);
					check_field("word_in_line", due_w.word_in_line, out_data.word_in_line);
					check_field("ends_line", 16'(due_w.ends_line), 16'(out_data.ends_line));
					check_field("overflow", 16'(due_w.overflow), 16'(out_data.overflow));
					n_words++;
					if (out_data.ends_line) n_eol++;
					if (out_data.overflow) n_ovf++;
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off: the block fills up and must drop in_ready.
	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		logic [7:0] chr;
		clear_parse_state();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			chr = 8'(i);
			if (chr == CHR_LF || chr == CHR_CR) begin
				class_map[i] = CLS_NL;
			end else if (chr <= CHR_SPACE || chr >= CHR_DEL || chr == CHR_EQ || chr == CHR_BAR) begin
				class_map[i] = CLS_SEP;
			end else begin
				class_map[i] = CLS_WORD;
			end
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: table writes incl. ignored codes, quotes, brackets, newlines
		// inside both, a zero quote byte, an unused kind and end-of-data flushes.
		add_class(CH_DQ, CLS_QUOTE);
		add_class(CH_LPAR, CLS_OPEN);
		add_class(CH_RPAR, CLS_CLOSE);
		add_class(8'h00, CLS_QUOTE);
		add_class(CH_A, CODE_BAD_LO);
		add_class(8'hFF, CODE_BAD_HI);
		add_byte(CH_A);
		add_byte(8'hFF);
		add_byte(CH_DQ);
		add_byte(CHR_SPACE);
		add_byte(CHR_LF);
		add_byte(CH_DQ);
		add_byte(CH_LPAR);
		add_byte(CH_LPAR);
		add_byte(CH_A);
		add_byte(CH_RPAR);
		add_byte(CH_RPAR);
		add_byte(8'h00);
		add_item(KIND_UNUSED, 8'hFF, CODE_BAD_HI);
		add_byte(CH_A);
		add_end();
		add_end();
		add_byte(CHR_CR);
		add_byte(CH_LPAR);
		add_byte(CHR_LF);
		add_byte(CH_RPAR);
		add_byte(CHR_BAR);
		add_end();
		run_phase(0, 0);

		repeat (2) add_random_file(35);
		run_phase(0, 0);
		repeat (2) add_random_file(35);
		run_phase(51, 0);
		repeat (2) add_random_file(35);
		run_phase(0, 51);
		repeat (2) add_random_file(35);
		run_phase(11, 11);

		add_random_file(40);
		hold_req = 1'b1;
		run_phase(0, 0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Tokenizer run: %0d items accepted, %0d words checked", n_items, n_words);
		$display("  (%0d newline-ended, %0d flagged overflow).", n_eol, n_ovf);
		$display("Covered table rewrites, quotes, nested brackets, four idling mixes and a long output stall.");
		if (n_errors == 0 && words_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Timeout: %0d words still expected, %0d items unsent",
			words_due.size(), items_to_send.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
